// ===== design/g7g_pkg.sv =====
// Shared types and constants for the G.711 codec with gain.
package g7g_pkg;

    typedef enum logic [1:0] {
        OP_MU_DEC = 2'd0,
        OP_A_DEC  = 2'd1,
        OP_MU_ENC = 2'd2,
        OP_GAIN   = 2'd3
    } op_t;

    localparam logic [15:0] UNITY_Q12 = 16'd4096;
    localparam logic [8:0]  MU_BIAS   = 9'h084;
    localparam logic [16:0] MU_CLIP   = 17'd32635;
    localparam logic [7:0]  A_XOR     = 8'h55;
    localparam logic [9:0]  A_BIAS    = 10'h108;
    localparam logic [33:0] Q12_HALF  = 34'd2048;

    // stage 1 -> stage 2
    typedef struct packed {
        op_t                op;
        logic signed [15:0] dec_sample;
        logic signed [15:0] lin;
        logic [16:0]        mag;
        logic [15:0]        gain;
        logic               unity;
        logic [14:0]        enc_mag;
    } s1_t;

    // stage 2 -> stage 3
    typedef struct packed {
        op_t                op;
        logic signed [15:0] dec_sample;
        logic signed [15:0] lin;
        logic               neg;
        logic               unity;
        logic [32:0]        prod;
        logic [14:0]        enc_mag;
        logic [2:0]         enc_seg;
    } s2_t;

endpackage

// ===== design/g7g_decode.sv =====
// Mu-law and A-law byte to 16-bit linear sample expansion.
module g7g_decode (
    input  logic [7:0]         code_byte,
    input  logic               alaw,
    output logic signed [15:0] sample
);
    import g7g_pkg::*;

    logic [7:0]  mu_v;
    logic [8:0]  mu_base;
    logic [15:0] mu_mag;
    logic [15:0] mu_lin;
    logic [7:0]  a_v;
    logic [2:0]  a_seg;
    logic [9:0]  a_base;
    logic [15:0] a_mag;

    always_comb
    begin
        mu_v    = ~code_byte;
        mu_base = {2'b00, mu_v[3:0], 3'b000} + MU_BIAS;
        mu_mag  = 16'(mu_base) << mu_v[6:4];
        mu_lin  = mu_mag - 16'(MU_BIAS);

        a_v    = code_byte ^ A_XOR;
        a_seg  = a_v[6:4];
        a_base = {2'b00, a_v[3:0], 4'b0000};
        if (a_seg == 3'd0)
        begin
            a_mag = 16'(a_base) + 16'd8;
        end
        else
        begin
            a_mag = 16'(a_base + A_BIAS) << (a_seg - 3'd1);
        end

        if (alaw)
        begin
            sample = a_v[7] ? signed'(a_mag) : -signed'(a_mag);
        end
        else
        begin
            sample = mu_v[7] ? -signed'(mu_lin) : signed'(mu_lin);
        end
    end

endmodule

// ===== design/g711_codec_with_gain.sv =====
// G.711 mu-law/A-law codec with Q12 gain, three-stage pipeline.
// Each request passes through the stage 1, stage 2 and result registers before result valid.
// Throughput: one request per cycle while the output is not stalled; stage 2 holds the 17x16 gain multiplier.
// Stalls ripple back stage by stage; empty stages accept while later ones wait.
// Reset (rst_n, async low) empties the pipeline and sets the gain register to 4096.
module g711_codec_with_gain (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  g7g_pkg::op_t       opcode,
    input  logic [7:0]         code_byte,
    input  logic signed [15:0] linear_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    output logic [7:0]         code_out
);
    import g7g_pkg::*;

    logic [15:0]        gain_reg;
    logic               v1_reg, v2_reg, v3_reg;
    s1_t                s1_reg, s1_next;
    s2_t                s2_reg, s2_next;
    logic signed [15:0] sample_reg, sample_next;
    logic [7:0]         code_reg, code_next;
    logic               adv1, adv2, adv3;
    logic signed [15:0] dec_sample;
    logic [15:0]        g_eff;
    logic [16:0]        clip_mag;
    logic [21:0]        q_mag;
    logic signed [15:0] gain_out;
    logic [3:0]         mant;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    g7g_decode u_dec (
        .code_byte (code_byte),
        .alaw      (opcode == OP_A_DEC),
        .sample    (dec_sample)
    );

    // stage 1: decode, magnitude, encoder clip and bias
    always_comb
    begin
        g_eff              = (gain_reg == 16'd0) ? UNITY_Q12 : gain_reg;
        s1_next.op         = opcode;
        s1_next.dec_sample = dec_sample;
        s1_next.lin        = linear_sample;
        s1_next.mag        = linear_sample[15] ? 17'(-17'(signed'(linear_sample)))
                                               : 17'(linear_sample);
        s1_next.gain       = g_eff;
        s1_next.unity      = (g_eff == UNITY_Q12);
        clip_mag           = (s1_next.mag > MU_CLIP) ? MU_CLIP : s1_next.mag;
        s1_next.enc_mag    = 15'(clip_mag + 17'(MU_BIAS));
    end

    // stage 2: gain multiply, encoder segment search
    always_comb
    begin
        s2_next.op         = s1_reg.op;
        s2_next.dec_sample = s1_reg.dec_sample;
        s2_next.lin        = s1_reg.lin;
        s2_next.neg        = s1_reg.lin[15];
        s2_next.unity      = s1_reg.unity;
        s2_next.prod       = s1_reg.mag * s1_reg.gain;
        s2_next.enc_mag    = s1_reg.enc_mag;
        s2_next.enc_seg    = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (s1_reg.enc_mag[7 + i])
            begin
                s2_next.enc_seg = 3'(i);
            end
        end
    end

    // stage 3: round half away from zero, saturate, pack mu-law byte, select the result by opcode
    always_comb
    begin
        q_mag = 22'((34'(s2_reg.prod) + Q12_HALF) >> 12);
        if (s2_reg.neg)
        begin
            gain_out = (q_mag > 22'd32768) ? -16'sd32768 : 16'(-q_mag);
        end
        else
        begin
            gain_out = (q_mag > 22'd32767) ? 16'sd32767 : 16'(q_mag);
        end
        mant = 4'(s2_reg.enc_mag >> ({1'b0, s2_reg.enc_seg} + 4'd3));

        code_next = 8'd0;
        case (s2_reg.op) inside
            OP_MU_DEC, OP_A_DEC: sample_next = s2_reg.dec_sample;
            OP_MU_ENC:
            begin
                sample_next = 16'sd0;
                code_next   = ~{s2_reg.neg, s2_reg.enc_seg, mant};
            end
            default:   sample_next = s2_reg.unity ? s2_reg.lin : gain_out;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= UNITY_Q12;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_wdata;
            end
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            sample_reg <= sample_next;
            code_reg   <= code_next;
        end
    end

    assign out_valid  = v3_reg;
    assign sample_out = sample_reg;
    assign code_out   = code_reg;

endmodule

// ===== design/g7g_checker.sv =====
// Port-level checks for the G.711 codec pipeline, bound to the top level.
module g7g_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input g7g_pkg::op_t       opcode,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] sample_out,
    input logic [7:0]         code_out
);
    import g7g_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(code_out))
        else $error("result changed while stalled");

    // with no output stall, an encode request reaches the output with sample_out zero
    a_enc_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_MU_ENC) ##1 out_ready ##1 out_ready
        |=> out_valid && sample_out == 16'sd0)
        else $error("encode result missing or sample not zero");

    // non-encode requests leave code_out zero
    a_dec_code: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode != OP_MU_ENC) ##1 out_ready ##1 out_ready
        |=> out_valid && code_out == 8'd0)
        else $error("code_out not zero for non-encode request");

    // mu-law decode never yields a magnitude above 32124
    a_mu_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_MU_DEC) ##1 out_ready ##1 out_ready
        |=> out_valid && sample_out <= 16'sd32124 && sample_out >= -16'sd32124)
        else $error("mu-law decode out of range");

endmodule

bind g711_codec_with_gain g7g_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .code_out   (code_out)
);

// ===== tb/sv/tb_g711_codec_with_gain.sv =====
// Testbench for g711_codec_with_gain: random G.711 decode/encode/gain requests checked in order.
module tb_g711_codec_with_gain;
    import g7g_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        op_t                op;
        logic [7:0]         code;
        logic signed [15:0] lin;
    } codec_req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [7:0]         code;
    } codec_res_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_COMB, RX_HEAVY} rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    op_t                opcode = OP_MU_DEC;
    logic [7:0]         code_byte = '0;
    logic signed [15:0] linear_sample = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] sample_out;
    logic [7:0]         code_out;

    codec_req_t  req_backlog[$];
    codec_res_t  results_due[$];
    logic [15:0] gain_setting = UNITY_Q12;
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_tick = 0;

    g711_codec_with_gain uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .code_byte     (code_byte),
        .linear_sample (linear_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .code_out      (code_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic codec_res_t codec_predict(op_t op, logic [7:0] code,
                                                 logic signed [15:0] lin,
                                                 logic [15:0] gain);
        codec_res_t r;
        logic [7:0] v;
        int         mag;
        int         seg;
        int         t;
        int         s;
        int         g;
        longint     prod;
        longint     pmag;
        longint     q;
        r = '0;
        case (op)
            OP_MU_DEC:
            begin
                v = ~code;
                mag = ((int'(v[3:0]) << 3) + int'(MU_BIAS)) << v[6:4];
                s = v[7] ? int'(MU_BIAS) - mag : mag - int'(MU_BIAS);
                r.sample = s[15:0];
            end
            OP_A_DEC:
            begin
                v = code ^ A_XOR;
                seg = int'(v[6:4]);
                t = int'(v[3:0]) << 4;
                if (seg == 0)
                    t = t + 8;
                else
                    t = (t + int'(A_BIAS)) << (seg - 1);
                s = v[7] ? t : -t;
                r.sample = s[15:0];
            end
            OP_MU_ENC:
            begin
                s = lin;
                mag = (s < 0) ? -s : s;
                if (mag > int'(MU_CLIP))
                    mag = int'(MU_CLIP);
                mag = mag + int'(MU_BIAS);
                seg = 7;
                // find the top set bit among 14..8 (segment 0 if none)
                while (seg > 0 && ((mag >> (seg + 7)) & 1) == 0)
                    seg--;
                t = ((s < 0) ? 8'h80 : 0) | (seg << 4) | ((mag >> (seg + 3)) & 15);
                r.code = ~t[7:0];
            end
            default:
            begin
                g = (gain == 0) ? int'(UNITY_Q12) : int'(gain);
                if (g == int'(UNITY_Q12))
                begin
                    r.sample = lin;
                end
                else
                begin
                    prod = longint'(lin) * longint'(g);
                    pmag = (prod < 0) ? -prod : prod;
                    pmag = (pmag + longint'(Q12_HALF)) >> 12;
                    q = (prod < 0) ? -pmag : pmag;
                    if (q > 32767)
                        q = 32767;
                    else if (q < -32768)
                        q = -32768;
                    r.sample = q[15:0];
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic queue_request(input op_t op, input logic [7:0] code,
                                 input logic signed [15:0] lin);
        codec_req_t r;
        r.op = op;
        r.code = code;
        r.lin = lin;
        req_backlog.push_back(r);
    endtask

    // biased toward the edges that matter for clipping and saturation
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] edges[8];
        int                 sel;
        edges = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1,
                  16'sd32635, -16'sd32635, 16'sd32636};
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return edges[$urandom_range(0, 7)];
        else if (sel == 1)
            return 16'($signed($urandom_range(0, 511)) - 256);
        return 16'($urandom);
    endfunction

    // checked between edges so the driver's and monitor's updates have settled
    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        codec_req_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0 || req_backlog.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
            else
            begin
                r = req_backlog.pop_front();
                in_valid <= 1'b1;
                opcode <= r.op;
                code_byte <= r.code;
                linear_sample <= r.lin;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: picks a new random stall mode whenever its tick counter runs out
    always @(posedge clk or negedge rst_n)
    begin : drive_out_ready
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_tick == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_tick = $urandom_range(16, 80);
            end
            else
            begin
                rx_tick--;
            end
            case (rx_mode)
                RX_OPEN:  out_ready <= 1'b1;
                RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                RX_COMB:  out_ready <= (rx_tick[1:0] == 2'd0);
                default:  out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : watch_ports
        codec_res_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                results_due.push_back(codec_predict(opcode, code_byte, linear_sample,
                                                    gain_setting));
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    flag_error($sformatf("result with no request pending: sample %0d code %02h",
                                         sample_out, code_out));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (sample_out !== want.sample)
                        flag_error($sformatf("sample_out %0d, expected %0d",
                                             sample_out, want.sample));
                    if (code_out !== want.code)
                        flag_error($sformatf("code_out %02h, expected %02h",
                                             code_out, want.code));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] gains[9];
        gains = '{16'd0, 16'd65535, 16'd1, 16'd2048, 16'd6144, 16'd4097,
                  16'($urandom), 16'($urandom_range(0, 8191)), UNITY_Q12};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // decode extremes, sign/segment corners, unused inputs nonzero
        queue_request(OP_MU_DEC, 8'h00, 16'sh7FFF);
        queue_request(OP_MU_DEC, 8'hFF, -16'sd32768);
        queue_request(OP_MU_DEC, 8'h7F, 16'sd0);
        queue_request(OP_MU_DEC, 8'h80, -16'sd1);
        queue_request(OP_A_DEC, 8'h00, 16'sh5555);
        queue_request(OP_A_DEC, 8'hFF, 16'sd0);
        queue_request(OP_A_DEC, 8'h55, 16'sd0);
        queue_request(OP_A_DEC, 8'hD5, -16'sd1);
        queue_request(OP_A_DEC, 8'h2A, 16'sd1);
        // encode: clip boundary and the most negative sample
        queue_request(OP_MU_ENC, 8'hFF, 16'sd32767);
        queue_request(OP_MU_ENC, 8'hFF, -16'sd32768);
        queue_request(OP_MU_ENC, 8'hAA, 16'sd0);
        queue_request(OP_MU_ENC, 8'h00, -16'sd1);
        queue_request(OP_MU_ENC, 8'h00, 16'sd32635);
        queue_request(OP_MU_ENC, 8'h00, 16'sd32636);
        queue_request(OP_MU_ENC, 8'h00, -16'sd32636);
        // unity gain passes through
        queue_request(OP_GAIN, 8'hFF, 16'sd32767);
        queue_request(OP_GAIN, 8'hFF, -16'sd32768);
        queue_request(OP_GAIN, 8'h00, 16'sd0);
        queue_request(OP_GAIN, 8'h00, -16'sd1);

        foreach (gains[i])
        begin
            wait_idle();
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= gains[i];
            gain_setting = gains[i];
            @(posedge clk);
            cfg_we <= 1'b0;
            repeat (100)
                queue_request(op_t'($urandom_range(0, 3)), 8'($urandom), pick_sample());
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
